// ----- design/ppuds_pkg.sv -----
package ppuds_pkg;

  localparam int unsigned KeyWidth = 37;
  localparam logic [2:0] TickLastLane = 3'd6;
  localparam logic [2:0] KeyLastLane = 3'd2;

  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_DRAW  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SP_RD,
    ST_SP_CK,
    ST_TK_RD,
    ST_TK_MUL,
    ST_TK_ADD,
    ST_TK_WR,
    ST_KY_RD,
    ST_KY_MUL,
    ST_KY_ADD,
    ST_KY_WR,
    ST_RK_RD,
    ST_RK_CMP,
    ST_SC_RD,
    ST_SC_WR,
    ST_CP_RD,
    ST_CP_WR
  } state_e;

  typedef struct packed {
    logic [47:0] pos;
    logic [47:0] vel;
    logic [63:0] col;
    logic [63:0] fade;
    logic [15:0] size;
    logic [15:0] life;
  } pool_ent_t;

  typedef struct packed {
    logic       capture;
    logic       use_slot;
    logic       spawn_chk;
    logic       tick_mul;
    logic       tick_add;
    logic       tick_wr;
    logic       key_mul;
    logic       key_add;
    logic       key_wr;
    logic       clr_rank;
    logic       rank_cmp;
    logic       scat_wr;
    logic       copy_wr;
    logic       clr_nlive;
    logic [2:0] lane;
  } cmd_t;

  typedef struct packed {
    logic enabled;
    logic slot_ok;
  } status_t;

endpackage

// ----- design/particle_pool_update_and_depth_sort_core.sv -----
// One transaction at a time; busy_o stays high until its work is done.
// Draw results leave during the final copy pass, one per live particle.
// The receiver cannot stall; each result is shown for one cycle on result_valid_o.
// Reset: pool reads as all dead via per-slot valid flags, spawn slot N-1, enabled 1.
module particle_pool_update_and_depth_sort_core #(
  parameter int unsigned MAX_PARTICLES = 64,
  parameter int unsigned FRAC_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [47:0] position_or_camera_i,
  input  logic [47:0] velocity_i,
  input  logic [63:0] colour_i,
  input  logic [63:0] fade_i,
  input  logic [15:0] size_i,
  input  logic [14:0] life_or_dt_i,
  output logic        result_valid_o,
  output logic [47:0] live_position_o,
  output logic [15:0] live_size_o,
  output logic [63:0] live_colour_o,
  output logic        last_o
);

  localparam int unsigned IW = $clog2(MAX_PARTICLES);

  ppuds_pkg::cmd_t    cmd;
  ppuds_pkg::status_t status;
  logic [IW-1:0]      idx_i, idx_j;

  ppuds_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .i_o       (idx_i),
    .j_o       (idx_j),
    .busy_o    (busy_o)
  );

  ppuds_dp #(.MAX_PARTICLES(MAX_PARTICLES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .i_i                  (idx_i),
    .j_i                  (idx_j),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .position_or_camera_i (position_or_camera_i),
    .velocity_i           (velocity_i),
    .colour_i             (colour_i),
    .fade_i               (fade_i),
    .size_i               (size_i),
    .life_or_dt_i         (life_or_dt_i),
    .status_o             (status),
    .result_valid_o       (result_valid_o),
    .live_position_o      (live_position_o),
    .live_size_o          (live_size_o),
    .live_colour_o        (live_colour_o),
    .last_o               (last_o)
  );

endmodule

// ----- design/ppuds_ram.sv -----
module ppuds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ppuds_ctrl.sv -----
module ppuds_ctrl #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [1:0]                       command_i,
  input  ppuds_pkg::status_t               status_i,
  output ppuds_pkg::cmd_t                  cmd_o,
  output logic [$clog2(MAX_PARTICLES)-1:0] i_o,
  output logic [$clog2(MAX_PARTICLES)-1:0] j_o,
  output logic                             busy_o
);

  localparam int unsigned IW = $clog2(MAX_PARTICLES);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_PARTICLES - 1);

  ppuds_pkg::state_e state_q, state_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [2:0]    lane_q, lane_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppuds_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      lane_q  <= lane_d;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    lane_d  = lane_q;
    cmd_o   = '0;
    cmd_o.lane = lane_q;
    case (state_q)
      ppuds_pkg::ST_IDLE: begin
        cmd_o.capture = start_i;
        if (start_i) begin
          case (ppuds_pkg::cmd_e'(command_i))
            ppuds_pkg::CMD_SPAWN: begin
              if (status_i.enabled && status_i.slot_ok) state_d = ppuds_pkg::ST_SP_RD;
            end
            ppuds_pkg::CMD_TICK: begin
              i_d     = '0;
              state_d = ppuds_pkg::ST_TK_RD;
            end
            ppuds_pkg::CMD_DRAW: begin
              if (status_i.enabled) begin
                i_d             = '0;
                cmd_o.clr_nlive = 1'b1;
                state_d         = ppuds_pkg::ST_KY_RD;
              end
            end
            default: state_d = ppuds_pkg::ST_IDLE;
          endcase
        end
      end
      ppuds_pkg::ST_SP_RD: begin
        cmd_o.use_slot = 1'b1;
        state_d        = ppuds_pkg::ST_SP_CK;
      end
      ppuds_pkg::ST_SP_CK: begin
        cmd_o.use_slot  = 1'b1;
        cmd_o.spawn_chk = 1'b1;
        state_d         = ppuds_pkg::ST_IDLE;
      end
      ppuds_pkg::ST_TK_RD: begin
        lane_d  = '0;
        state_d = ppuds_pkg::ST_TK_MUL;
      end
      ppuds_pkg::ST_TK_MUL: begin
        cmd_o.tick_mul = 1'b1;
        state_d        = ppuds_pkg::ST_TK_ADD;
      end
      ppuds_pkg::ST_TK_ADD: begin
        cmd_o.tick_add = 1'b1;
        if (lane_q == ppuds_pkg::TickLastLane) begin
          state_d = ppuds_pkg::ST_TK_WR;
        end else begin
          lane_d  = lane_q + 3'd1;
          state_d = ppuds_pkg::ST_TK_MUL;
        end
      end
      ppuds_pkg::ST_TK_WR: begin
        cmd_o.tick_wr = 1'b1;
        if (i_q == LastIdx) begin
          state_d = ppuds_pkg::ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ppuds_pkg::ST_TK_RD;
        end
      end
      ppuds_pkg::ST_KY_RD: begin
        lane_d  = '0;
        state_d = ppuds_pkg::ST_KY_MUL;
      end
      ppuds_pkg::ST_KY_MUL: begin
        cmd_o.key_mul = 1'b1;
        state_d       = ppuds_pkg::ST_KY_ADD;
      end
      ppuds_pkg::ST_KY_ADD: begin
        cmd_o.key_add = 1'b1;
        if (lane_q == ppuds_pkg::KeyLastLane) begin
          state_d = ppuds_pkg::ST_KY_WR;
        end else begin
          lane_d  = lane_q + 3'd1;
          state_d = ppuds_pkg::ST_KY_MUL;
        end
      end
      ppuds_pkg::ST_KY_WR: begin
        cmd_o.key_wr   = 1'b1;
        cmd_o.clr_rank = 1'b1;
        if (i_q == LastIdx) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ppuds_pkg::ST_RK_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ppuds_pkg::ST_KY_RD;
        end
      end
      ppuds_pkg::ST_RK_RD: begin
        state_d = ppuds_pkg::ST_RK_CMP;
      end
      ppuds_pkg::ST_RK_CMP: begin
        cmd_o.rank_cmp = 1'b1;
        if (j_q == LastIdx) begin
          state_d = ppuds_pkg::ST_SC_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ppuds_pkg::ST_RK_RD;
        end
      end
      ppuds_pkg::ST_SC_RD: begin
        state_d = ppuds_pkg::ST_SC_WR;
      end
      ppuds_pkg::ST_SC_WR: begin
        cmd_o.scat_wr  = 1'b1;
        cmd_o.clr_rank = 1'b1;
        j_d            = '0;
        if (i_q == LastIdx) begin
          i_d     = '0;
          state_d = ppuds_pkg::ST_CP_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ppuds_pkg::ST_RK_RD;
        end
      end
      ppuds_pkg::ST_CP_RD: begin
        state_d = ppuds_pkg::ST_CP_WR;
      end
      ppuds_pkg::ST_CP_WR: begin
        cmd_o.copy_wr = 1'b1;
        if (i_q == LastIdx) begin
          state_d = ppuds_pkg::ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ppuds_pkg::ST_CP_RD;
        end
      end
      default: state_d = ppuds_pkg::ST_IDLE;
    endcase
  end

  assign i_o    = i_q;
  assign j_o    = j_q;
  assign busy_o = (state_q != ppuds_pkg::ST_IDLE);

endmodule

// ----- design/ppuds_dp.sv -----
module ppuds_dp #(
  parameter int unsigned MAX_PARTICLES = 64,
  parameter int unsigned FRAC_BITS     = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ppuds_pkg::cmd_t                  cmd_i,
  input  logic [$clog2(MAX_PARTICLES)-1:0] i_i,
  input  logic [$clog2(MAX_PARTICLES)-1:0] j_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_data_i,
  input  logic [47:0]                      position_or_camera_i,
  input  logic [47:0]                      velocity_i,
  input  logic [63:0]                      colour_i,
  input  logic [63:0]                      fade_i,
  input  logic [15:0]                      size_i,
  input  logic [14:0]                      life_or_dt_i,
  output ppuds_pkg::status_t               status_o,
  output logic                             result_valid_o,
  output logic [47:0]                      live_position_o,
  output logic [15:0]                      live_size_o,
  output logic [63:0]                      live_colour_o,
  output logic                             last_o
);

  localparam int unsigned IW = $clog2(MAX_PARTICLES);
  localparam int unsigned KW = ppuds_pkg::KeyWidth;

  ppuds_pkg::pool_ent_t in_q, pool_rd, pool_wdata, scr_rd, scr_wdata;
  logic                 enabled_q;
  logic signed [IW:0]   slot_q;
  logic [IW:0]          nlive_q;
  logic [IW-1:0]        rank_q;
  logic [MAX_PARTICLES-1:0] valid_q;
  logic [IW-1:0]        pool_raddr, pool_waddr, rd_addr_q;
  logic                 pool_we, live;
  logic [KW-1:0]        key_a, key_b, key_w, acc_q;
  logic signed [33:0]   prod_q, step, sum;
  logic signed [16:0]   mul_a, mul_b, diff;
  logic [15:0]          rate_l [8];
  logic [15:0]          val_l [8];
  logic [15:0]          cam_l [8];
  logic [7:0][15:0]     upd_q;
  logic [15:0]          sat_v, life_new;
  logic                 res_valid_q, res_last_q;
  logic [47:0]          res_pos_q;
  logic [15:0]          res_size_q;
  logic [63:0]          res_col_q;

  assign pool_raddr = cmd_i.use_slot ? slot_q[IW-1:0] : i_i;
  assign live       = valid_q[rd_addr_q] && (pool_rd.life != 16'd0);

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      rate_l[l] = '0;
      val_l[l]  = '0;
      cam_l[l]  = '0;
    end
    for (int l = 0; l < 3; l++) begin
      rate_l[l] = pool_rd.vel[16*l +: 16];
      val_l[l]  = pool_rd.pos[16*l +: 16];
      cam_l[l]  = in_q.pos[16*l +: 16];
    end
    for (int l = 0; l < 4; l++) begin
      rate_l[l+3] = pool_rd.fade[16*l +: 16];
      val_l[l+3]  = pool_rd.col[16*l +: 16];
    end
  end

  assign diff  = $signed({cam_l[cmd_i.lane][15], cam_l[cmd_i.lane]})
               - $signed({val_l[cmd_i.lane][15], val_l[cmd_i.lane]});
  assign mul_a = cmd_i.key_mul ? diff : $signed({rate_l[cmd_i.lane][15], rate_l[cmd_i.lane]});
  assign mul_b = cmd_i.key_mul ? diff : $signed({2'b00, in_q.life[14:0]});

  assign step = prod_q >>> FRAC_BITS;
  assign sum  = $signed({{18{val_l[cmd_i.lane][15]}}, val_l[cmd_i.lane]}) + step;

  always_comb begin
    if (sum > 34'sd32767) begin
      sat_v = 16'h7fff;
    end else if (sum < -34'sd32768) begin
      sat_v = 16'h8000;
    end else begin
      sat_v = sum[15:0];
    end
  end

  assign life_new = (pool_rd.life > {1'b0, in_q.life[14:0]})
                  ? pool_rd.life - {1'b0, in_q.life[14:0]} : 16'd0;
  assign key_w    = live ? acc_q + KW'(1) : '0;

  always_comb begin
    pool_we    = 1'b0;
    pool_waddr = i_i;
    pool_wdata = scr_rd;
    if (cmd_i.spawn_chk) begin
      pool_we    = !live;
      pool_waddr = slot_q[IW-1:0];
      pool_wdata = in_q;
    end else if (cmd_i.tick_wr) begin
      pool_we         = live;
      pool_wdata      = pool_rd;
      pool_wdata.pos  = {upd_q[2], upd_q[1], upd_q[0]};
      pool_wdata.col  = {upd_q[6], upd_q[5], upd_q[4], upd_q[3]};
      pool_wdata.life = life_new;
    end else if (cmd_i.copy_wr) begin
      pool_we = 1'b1;
    end
  end

  always_comb begin
    scr_wdata      = pool_rd;
    scr_wdata.life = live ? pool_rd.life : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      slot_q      <= (IW+1)'(MAX_PARTICLES - 1);
      nlive_q     <= '0;
      rank_q      <= '0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) enabled_q <= cfg_data_i;
      if (cmd_i.spawn_chk && !live) slot_q <= slot_q - 1'b1;
      if (cmd_i.copy_wr) slot_q <= (IW+1)'(MAX_PARTICLES - 1);
      if (cmd_i.clr_nlive) nlive_q <= '0;
      else if (cmd_i.key_wr && live) nlive_q <= nlive_q + 1'b1;
      if (cmd_i.clr_rank) begin
        rank_q <= '0;
      end else if (cmd_i.rank_cmp && ((key_b > key_a) || ((key_b == key_a) && (j_i < i_i)))) begin
        rank_q <= rank_q + 1'b1;
      end
      if (pool_we) valid_q[pool_waddr] <= 1'b1;
      res_valid_q <= cmd_i.copy_wr && ({1'b0, i_i} < nlive_q);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= pool_raddr;
    if (cmd_i.capture) begin
      in_q.pos  <= position_or_camera_i;
      in_q.vel  <= velocity_i;
      in_q.col  <= colour_i;
      in_q.fade <= fade_i;
      in_q.size <= size_i;
      in_q.life <= {1'b0, life_or_dt_i};
    end
    if (cmd_i.tick_mul || cmd_i.key_mul) prod_q <= mul_a * mul_b;
    if (cmd_i.tick_add) upd_q[cmd_i.lane] <= sat_v;
    if (cmd_i.key_add) begin
      acc_q <= ((cmd_i.lane == 3'd0) ? '0 : acc_q) + KW'(prod_q[33:0]);
    end
    if (cmd_i.copy_wr) begin
      res_pos_q  <= scr_rd.pos;
      res_size_q <= scr_rd.size;
      res_col_q  <= scr_rd.col;
      res_last_q <= (({1'b0, i_i} + 1'b1) == nlive_q);
    end
  end

  ppuds_ram #(.WIDTH($bits(ppuds_pkg::pool_ent_t)), .DEPTH(MAX_PARTICLES)) u_pool (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rd)
  );

  ppuds_ram #(.WIDTH($bits(ppuds_pkg::pool_ent_t)), .DEPTH(MAX_PARTICLES)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (cmd_i.scat_wr),
    .waddr_i (rank_q),
    .wdata_i (scr_wdata),
    .raddr_i (i_i),
    .rdata_o (scr_rd)
  );

  ppuds_ram #(.WIDTH(KW), .DEPTH(MAX_PARTICLES)) u_key_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_wr),
    .waddr_i (i_i),
    .wdata_i (key_w),
    .raddr_i (i_i),
    .rdata_o (key_a)
  );

  ppuds_ram #(.WIDTH(KW), .DEPTH(MAX_PARTICLES)) u_key_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_wr),
    .waddr_i (i_i),
    .wdata_i (key_w),
    .raddr_i (j_i),
    .rdata_o (key_b)
  );

  assign status_o.enabled = enabled_q;
  assign status_o.slot_ok = !slot_q[IW];
  assign result_valid_o   = res_valid_q;
  assign live_position_o  = res_pos_q;
  assign live_size_o      = res_size_q;
  assign live_colour_o    = res_col_q;
  assign last_o           = res_valid_q && res_last_q;

endmodule

// ----- design/ppuds_checker.sv -----
module ppuds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] command_i,
  input logic       result_valid_o,
  input logic       last_o
);

  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o)
    else $error("last without a result");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without a running transaction");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> busy_o)
    else $error("draw ended before last result");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (command_i == ppuds_pkg::CMD_TICK) |=> busy_o)
    else $error("tick did not start");

endmodule

bind particle_pool_update_and_depth_sort_core ppuds_checker u_ppuds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .command_i      (command_i),
  .result_valid_o (result_valid_o),
  .last_o         (last_o)
);
